// File: rtl/core/multiword_signed_add_sub_mod_core_macros.svh
// assertion macros used by the checker file of the multiword add/sub core
`ifndef MULTIWORD_SIGNED_ADD_SUB_MOD_CORE_MACROS_SVH
`define MULTIWORD_SIGNED_ADD_SUB_MOD_CORE_MACROS_SVH

// same-cycle implication, checked at each rising edge outside reset
`define MWSAS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle property violated");

// next-cycle implication, checked at each rising edge outside reset
`define MWSAS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle property violated");

`endif

// File: rtl/core/mwsas_pkg.sv
// shared types and constants of the multiword signed add/sub/mod core
package mwsas_pkg;

	localparam int WORD_BITS = 32;
	localparam int NUM_WORDS = 8;
	localparam int IDX_W     = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int CNT_W     = $clog2(NUM_WORDS + 1);

	typedef enum logic [1:0] {
		OP_ADD  = 2'd0,
		OP_SUB  = 2'd1,
		OP_MADD = 2'd2,
		OP_MSUB = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ALU_ADD,
		ALU_SUB,
		ALU_CMP
	} alu_mode_t;

	typedef struct packed {
		logic [WORD_BITS-1:0] sum;
		logic                 carry;
		logic                 zero;
	} alu_res_t;

endpackage

// File: rtl/core/mwsas_alu.sv
// shared word adder/subtractor/comparator used by every pass of the sequencer
module mwsas_alu import mwsas_pkg::*; (
	input  logic [WORD_BITS-1:0] x,
	input  logic [WORD_BITS-1:0] y,
	input  alu_mode_t            mode,
	input  logic                 carry_in,
	output alu_res_t             res
);

	logic [WORD_BITS-1:0] y_eff;
	logic [WORD_BITS:0]   total;

	// subtract and compare use x + ~y + carry
	always_comb begin
		y_eff = (mode == ALU_ADD) ? y : ~y;
		total = {1'b0, x} + {1'b0, y_eff} + {{WORD_BITS{1'b0}}, carry_in};
		res.sum   = total[WORD_BITS-1:0];
		res.carry = total[WORD_BITS];
		res.zero  = (total[WORD_BITS-1:0] == '0);
	end

endmodule

// File: rtl/core/multiword_signed_add_sub_mod_core.sv
// top level of the multiword sign-magnitude add/sub/modular core
//
//  channel   dir  handshake                      payload
//  operand   in   operand_valid / operand_stall  op a_word b_word mod_word
//                                                a_negative b_negative last_word
//  result    out  result_valid / result_stall    result_word result_negative ok last
//
// operand words are taken one at a time; after the last word a dispatch step follows,
// then up to five passes over the stored words through one shared word adder, then
// the result words are handed out.
// reset clears the sequencer, counters and flags; the word stores are not cleared.
// operand_stall is high from the last operand word until the last result word has
// entered the output register; result_stall holds the output register and the
// sequencer in its output step.
module multiword_signed_add_sub_mod_core import mwsas_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 operand_valid,
	output logic                 operand_stall,
	input  logic [1:0]           op,
	input  logic [WORD_BITS-1:0] a_word,
	input  logic [WORD_BITS-1:0] b_word,
	input  logic [WORD_BITS-1:0] mod_word,
	input  logic                 a_negative,
	input  logic                 b_negative,
	input  logic                 last_word,
	output logic                 result_valid,
	input  logic                 result_stall,
	output logic [WORD_BITS-1:0] result_word,
	output logic                 result_negative,
	output logic                 ok,
	output logic                 last
);

	typedef enum logic [3:0] {
		S_LOAD,
		S_DISPATCH,
		S_ADD_AB,
		S_CMP_AB,
		S_SUB_AB,
		S_SUB_BA,
		S_CMP_AM,
		S_CMP_BM,
		S_CMP_RM,
		S_SUB_RM,
		S_SUB_MR,
		S_OUT
	} state_t;

	state_t               state_q;
	op_t                  op_q;
	logic                 a_neg_q;
	logic                 b_neg_q;
	logic [CNT_W-1:0]     count_q;
	logic [IDX_W-1:0]     idx_q;
	logic                 carry_q;
	logic                 eq_q;
	logic                 gt_q;
	logic                 nz_q;
	logic                 sign_q;
	logic                 ok_q;
	logic                 result_valid_q;
	logic [WORD_BITS-1:0] result_word_q;
	logic                 result_negative_q;
	logic                 ok_out_q;
	logic                 last_q;

	logic [WORD_BITS-1:0] first_store_q   [NUM_WORDS];
	logic [WORD_BITS-1:0] second_store_q  [NUM_WORDS];
	logic [WORD_BITS-1:0] modulus_store_q [NUM_WORDS];
	logic [WORD_BITS-1:0] result_store_q  [NUM_WORDS];

	logic [WORD_BITS-1:0] x_word;
	logic [WORD_BITS-1:0] y_word;
	alu_mode_t            mode;
	logic                 wr_res;
	logic                 carry_in;
	alu_res_t             alu_res;
	logic                 eq_n;
	logic                 gt_n;
	logic                 ge_n;
	logic                 nz_n;
	logic                 is_last;
	logic                 is_plain;
	logic                 store_wr;
	logic                 out_take;
	logic [CNT_W-1:0]     cnt_last;

	// operand routing for the current pass
	always_comb begin
		x_word = first_store_q[idx_q];
		y_word = second_store_q[idx_q];
		mode   = ALU_ADD;
		wr_res = 1'b0;
		case (state_q)
			S_ADD_AB: begin
				wr_res = 1'b1;
			end
			S_CMP_AB: begin
				mode = ALU_CMP;
			end
			S_SUB_AB: begin
				mode   = ALU_SUB;
				wr_res = 1'b1;
			end
			S_SUB_BA: begin
				x_word = second_store_q[idx_q];
				y_word = first_store_q[idx_q];
				mode   = ALU_SUB;
				wr_res = 1'b1;
			end
			S_CMP_AM: begin
				y_word = modulus_store_q[idx_q];
				mode   = ALU_CMP;
			end
			S_CMP_BM: begin
				x_word = second_store_q[idx_q];
				y_word = modulus_store_q[idx_q];
				mode   = ALU_CMP;
			end
			S_CMP_RM: begin
				x_word = result_store_q[idx_q];
				y_word = modulus_store_q[idx_q];
				mode   = ALU_CMP;
			end
			S_SUB_RM: begin
				x_word = result_store_q[idx_q];
				y_word = modulus_store_q[idx_q];
				mode   = ALU_SUB;
				wr_res = 1'b1;
			end
			S_SUB_MR: begin
				x_word = modulus_store_q[idx_q];
				y_word = result_store_q[idx_q];
				mode   = ALU_SUB;
				wr_res = 1'b1;
			end
			default: ;
		endcase
	end

	// carry chain restarts at word zero; compare looks at each word alone
	always_comb begin
		if (mode == ALU_CMP) begin
			carry_in = 1'b1;
		end else if (idx_q == '0) begin
			carry_in = (mode == ALU_SUB);
		end else begin
			carry_in = carry_q;
		end
	end

	mwsas_alu u_alu (
		.x        (x_word),
		.y        (y_word),
		.mode     (mode),
		.carry_in (carry_in),
		.res      (alu_res)
	);

	// running compare and zero flags, the highest differing word wins
	assign eq_n     = eq_q & alu_res.zero;
	assign gt_n     = alu_res.zero ? gt_q : alu_res.carry;
	assign ge_n     = eq_n | gt_n;
	assign nz_n     = nz_q | ~alu_res.zero;
	assign cnt_last = count_q - CNT_W'(1);
	assign is_last  = (CNT_W'(idx_q) == cnt_last);
	assign is_plain = (op_q == OP_ADD) || (op_q == OP_SUB);
	assign store_wr = (state_q == S_LOAD) && operand_valid && (count_q < CNT_W'(NUM_WORDS));
	assign out_take = (state_q == S_OUT) && (!result_valid_q || !result_stall);

	// word stores
	always_ff @(posedge clk) begin
		if (store_wr) begin
			first_store_q[count_q[IDX_W-1:0]]   <= a_word;
			second_store_q[count_q[IDX_W-1:0]]  <= b_word;
			modulus_store_q[count_q[IDX_W-1:0]] <= mod_word;
		end
		if (wr_res) begin
			result_store_q[idx_q] <= alu_res.sum;
		end
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= S_LOAD;
			op_q              <= OP_ADD;
			a_neg_q           <= 1'b0;
			b_neg_q           <= 1'b0;
			count_q           <= '0;
			idx_q             <= '0;
			carry_q           <= 1'b0;
			eq_q              <= 1'b1;
			gt_q              <= 1'b0;
			nz_q              <= 1'b0;
			sign_q            <= 1'b0;
			ok_q              <= 1'b0;
			result_valid_q    <= 1'b0;
			result_word_q     <= '0;
			result_negative_q <= 1'b0;
			ok_out_q          <= 1'b0;
			last_q            <= 1'b0;
		end else begin
			// output register valid: loaded by the output step, cleared once taken
			if (out_take) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				// take operand words, op and signs come with the first one
				S_LOAD: begin
					if (operand_valid) begin
						if (count_q == '0) begin
							op_q    <= op_t'(op);
							a_neg_q <= a_negative;
							b_neg_q <= b_negative;
						end
						if (count_q < CNT_W'(NUM_WORDS)) begin
							count_q <= count_q + CNT_W'(1);
						end
						if (last_word) begin
							state_q <= S_DISPATCH;
						end
					end
				end
				// pick the first pass from op and signs, or go straight to output for a negative modular operand
				S_DISPATCH: begin
					idx_q <= '0;
					eq_q  <= 1'b1;
					gt_q  <= 1'b0;
					nz_q  <= 1'b0;
					if (is_plain) begin
						ok_q <= 1'b1;
						if (a_neg_q == (b_neg_q ^ (op_q == OP_SUB))) begin
							sign_q  <= a_neg_q;
							state_q <= S_ADD_AB;
						end else begin
							state_q <= S_CMP_AB;
						end
					end else if (a_neg_q || b_neg_q) begin
						ok_q    <= 1'b0;
						sign_q  <= 1'b0;
						state_q <= S_OUT;
					end else begin
						ok_q    <= 1'b1;
						state_q <= S_CMP_AM;
					end
				end
				// hand out result words, least significant first
				S_OUT: begin
					if (out_take) begin
						result_word_q     <= ok_q ? result_store_q[idx_q] : '0;
						result_negative_q <= sign_q;
						ok_out_q          <= ok_q;
						last_q            <= is_last;
						if (is_last) begin
							idx_q   <= '0;
							count_q <= '0;
							state_q <= S_LOAD;
						end else begin
							idx_q <= idx_q + IDX_W'(1);
						end
					end
				end
				// one word per cycle through the shared unit
				default: begin
					carry_q <= alu_res.carry;
					if (is_last) begin
						idx_q <= '0;
						eq_q  <= 1'b1;
						gt_q  <= 1'b0;
						nz_q  <= 1'b0;
						case (state_q)
							S_ADD_AB: begin
								state_q <= is_plain ? S_OUT : S_CMP_RM;
							end
							S_CMP_AB: begin
								if (gt_n) begin
									sign_q  <= a_neg_q;
									state_q <= S_SUB_AB;
								end else begin
									state_q <= S_SUB_BA;
								end
							end
							S_SUB_BA: begin
								// a zero difference is positive
								if (!nz_n) begin
									sign_q  <= 1'b0;
									state_q <= S_OUT;
								end else if (is_plain) begin
									sign_q  <= ~a_neg_q;
									state_q <= S_OUT;
								end else begin
									sign_q  <= 1'b0;
									state_q <= S_SUB_MR;
								end
							end
							S_CMP_AM: begin
								if (ge_n) begin
									ok_q    <= 1'b0;
									sign_q  <= 1'b0;
									state_q <= S_OUT;
								end else begin
									state_q <= S_CMP_BM;
								end
							end
							S_CMP_BM: begin
								if (ge_n) begin
									ok_q    <= 1'b0;
									sign_q  <= 1'b0;
									state_q <= S_OUT;
								end else if (op_q == OP_MADD) begin
									sign_q  <= 1'b0;
									state_q <= S_ADD_AB;
								end else begin
									state_q <= S_CMP_AB;
								end
							end
							S_CMP_RM: begin
								state_q <= ge_n ? S_SUB_RM : S_OUT;
							end
							S_SUB_AB, S_SUB_RM, S_SUB_MR: begin
								state_q <= S_OUT;
							end
							default: begin
								state_q <= S_LOAD;
							end
						endcase
					end else begin
						idx_q <= idx_q + IDX_W'(1);
						eq_q  <= eq_n;
						gt_q  <= gt_n;
						nz_q  <= nz_n;
					end
				end
			endcase
		end
	end

	assign operand_stall   = (state_q != S_LOAD);
	assign result_valid    = result_valid_q;
	assign result_word     = result_word_q;
	assign result_negative = result_negative_q;
	assign ok              = ok_out_q;
	assign last            = last_q;

endmodule

// File: rtl/core/mwsas_checker.sv
// port-level checker for the multiword add/sub core, bound to the top level
`include "multiword_signed_add_sub_mod_core_macros.svh"

module mwsas_checker import mwsas_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 operand_valid,
	input logic                 operand_stall,
	input logic                 last_word,
	input logic                 result_valid,
	input logic                 result_stall,
	input logic [WORD_BITS-1:0] result_word,
	input logic                 result_negative,
	input logic                 ok
);

	// a stalled result item stays offered
	`MWSAS_ASSERT_NEXT(a_result_held, clk, arst_n, result_valid && result_stall, result_valid)

	// a failed modular precondition gives a zero positive word
	`MWSAS_ASSERT_IMP(a_fail_zero, clk, arst_n, result_valid && !ok, result_word == '0 && !result_negative)

	// the closing operand word starts the computation and blocks further items
	`MWSAS_ASSERT_NEXT(a_last_blocks, clk, arst_n, operand_valid && !operand_stall && last_word, operand_stall)

	// an operand word that is not the last keeps the block loading
	`MWSAS_ASSERT_NEXT(a_mid_open, clk, arst_n, operand_valid && !operand_stall && !last_word, !operand_stall)

endmodule

bind multiword_signed_add_sub_mod_core mwsas_checker u_mwsas_checker (.*);

// File: tb/tb_multiword_signed_add_sub_mod_core.sv
// self-checking testbench of the multiword signed add/sub/modular core
module tb_multiword_signed_add_sub_mod_core import mwsas_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WIDE_BITS  = WORD_BITS * NUM_WORDS;
	localparam int RAND_ITEMS = 360;
	localparam int IDLE_LIMIT = 4000;
	localparam int TAIL_WAIT  = 60;

	typedef logic [WIDE_BITS-1:0] wide_t;

	typedef struct {
		op_t                  code;
		logic [WORD_BITS-1:0] a;
		logic [WORD_BITS-1:0] b;
		logic [WORD_BITS-1:0] m;
		logic                 a_neg;
		logic                 b_neg;
		logic                 closing;
		logic                 hold_off;
	} operand_item_t;

	typedef struct {
		logic [WORD_BITS-1:0] word;
		logic                 neg;
		logic                 good;
		logic                 closing;
	} result_item_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 operand_valid = 1'b0;
	logic                 operand_stall;
	logic [1:0]           op = '0;
	logic [WORD_BITS-1:0] a_word = '0;
	logic [WORD_BITS-1:0] b_word = '0;
	logic [WORD_BITS-1:0] mod_word = '0;
	logic                 a_negative = 1'b0;
	logic                 b_negative = 1'b0;
	logic                 last_word = 1'b0;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	logic [WORD_BITS-1:0] result_word;
	logic                 result_negative;
	logic                 ok;
	logic                 last;

	operand_item_t operand_queue[$];
	result_item_t  due_results[$];

	// predictor state: operands gathered so far for the open operation
	wide_t first_mag;
	wide_t second_mag;
	wide_t modulus_mag;
	logic  first_neg;
	logic  second_neg;
	op_t   held_op;
	int    words_in = 0;

	int   mismatches = 0;
	int   idle_cycles = 0;
	int   cycle_count = 0;
	logic operand_taken = 1'b0;
	logic calm;

	multiword_signed_add_sub_mod_core uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.operand_valid   (operand_valid),
		.operand_stall   (operand_stall),
		.op              (op),
		.a_word          (a_word),
		.b_word          (b_word),
		.mod_word        (mod_word),
		.a_negative      (a_negative),
		.b_negative      (b_negative),
		.last_word       (last_word),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.result_word     (result_word),
		.result_negative (result_negative),
		.ok              (ok),
		.last            (last)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// stretch of the run with no idling on either side
	assign calm = (cycle_count >= 1500) && (cycle_count < 3000);

	// sign-magnitude add of x and y, magnitudes wrap at the loaded width
	function automatic void sm_add(input wide_t x, input logic x_neg, input wide_t y,
			input logic y_neg, input wide_t msk, output wide_t r, output logic r_neg);
		if (x_neg == y_neg) begin
			r = (x + y) & msk;
			r_neg = x_neg;
		end else if (x > y) begin
			r = (x - y) & msk;
			r_neg = x_neg;
		end else begin
			r = (y - x) & msk;
			r_neg = (r == '0) ? 1'b0 : ~x_neg;
		end
	endfunction

	// fold one accepted operand item into the predictor, emit results on the last word
	task automatic predict_word(input op_t code, input logic [WORD_BITS-1:0] a,
			input logic [WORD_BITS-1:0] b, input logic [WORD_BITS-1:0] m,
			input logic a_neg, input logic b_neg, input logic closing);
		wide_t msk;
		wide_t res;
		logic  res_neg;
		logic  good;
		int    n;
		if (words_in == 0) begin
			held_op = code;
			first_neg = a_neg;
			second_neg = b_neg;
			first_mag = '0;
			second_mag = '0;
			modulus_mag = '0;
		end
		if (words_in < NUM_WORDS) begin
			first_mag[words_in*WORD_BITS +: WORD_BITS] = a;
			second_mag[words_in*WORD_BITS +: WORD_BITS] = b;
			modulus_mag[words_in*WORD_BITS +: WORD_BITS] = m;
			words_in++;
		end
		if (!closing)
			return;
		n = words_in;
		words_in = 0;
		msk = {WIDE_BITS{1'b1}} >> (WORD_BITS * (NUM_WORDS - n));
		good = 1'b1;
		res_neg = 1'b0;
		case (held_op)
			OP_ADD: sm_add(first_mag, first_neg, second_mag, second_neg, msk, res, res_neg);
			OP_SUB: sm_add(first_mag, first_neg, second_mag, ~second_neg, msk, res, res_neg);
			default: begin
				if (first_neg || second_neg || first_mag >= modulus_mag ||
						second_mag >= modulus_mag) begin
					good = 1'b0;
					res = '0;
				end else if (held_op == OP_MADD) begin
					res = (first_mag + second_mag) & msk;
					if (res >= modulus_mag)
						res = (res - modulus_mag) & msk;
				end else begin
					sm_add(first_mag, 1'b0, second_mag, 1'b1, msk, res, res_neg);
					// negative difference wraps back into the modulus range
					if (res_neg)
						res = (modulus_mag - res) & msk;
					res_neg = 1'b0;
				end
			end
		endcase
		for (int i = 0; i < n; i++)
			due_results.push_back('{res[i*WORD_BITS +: WORD_BITS], res_neg, good, i == n - 1});
	endtask

	// acceptance, prediction, result checking and watchdog
	always @(posedge clk) begin : monitor
		result_item_t want;
		operand_taken <= operand_valid && !operand_stall && arst_n;
		if (arst_n) begin
			cycle_count <= cycle_count + 1;
			if (operand_valid && !operand_stall)
				predict_word(op_t'(op), a_word, b_word, mod_word, a_negative, b_negative,
					last_word);
			if (result_valid && !result_stall) begin
				if (due_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result item: word %h neg %0b ok %0b last %0b",
							result_word, result_negative, ok, last);
				end else begin
					want = due_results.pop_front();
					if (result_word !== want.word || result_negative !== want.neg ||
							ok !== want.good || last !== want.closing) begin
						mismatches++;
						if (mismatches <= 10)
							$display("result mismatch: expected word %h neg %0b ok %0b last %0b, got word %h neg %0b ok %0b last %0b",
								want.word, want.neg, want.good, want.closing,
								result_word, result_negative, ok, last);
					end
				end
			end
			if ((operand_valid && !operand_stall) || (result_valid && !result_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb_multiword_signed_add_sub_mod_core NOT OK");
				$finish;
			end
		end
	end

	// operand driver and result stall, both change on the falling edge
	always @(negedge clk) begin : driver
		operand_item_t nxt;
		if (arst_n) begin
			if (!operand_valid || operand_taken) begin
				if (operand_queue.size() != 0 &&
						!(operand_queue[0].hold_off && due_results.size() != 0) &&
						!(!calm && $urandom_range(99) < 7)) begin
					nxt = operand_queue.pop_front();
					op <= nxt.code;
					a_word <= nxt.a;
					b_word <= nxt.b;
					mod_word <= nxt.m;
					a_negative <= nxt.a_neg;
					b_negative <= nxt.b_neg;
					last_word <= nxt.closing;
					operand_valid <= 1'b1;
				end else begin
					operand_valid <= 1'b0;
				end
			end
			result_stall <= calm ? 1'b0 : ($urandom_range(99) < 7);
		end
	end

	// queue one operation as a run of operand items, least significant word first
	task automatic queue_operation(input op_t code, input logic a_neg, input logic b_neg,
			input wide_t a, input wide_t b, input wide_t m, input int n, input bit hold_off);
		operand_item_t it;
		for (int i = 0; i < n; i++) begin
			// op and signs only count on the first word, so later words carry noise
			it.code = (i == 0) ? code : op_t'($urandom_range(3));
			it.a_neg = (i == 0) ? a_neg : 1'($urandom_range(1));
			it.b_neg = (i == 0) ? b_neg : 1'($urandom_range(1));
			if (i < NUM_WORDS) begin
				it.a = a[i*WORD_BITS +: WORD_BITS];
				it.b = b[i*WORD_BITS +: WORD_BITS];
				it.m = m[i*WORD_BITS +: WORD_BITS];
			end else begin
				it.a = $urandom();
				it.b = $urandom();
				it.m = $urandom();
			end
			it.closing = (i == n - 1);
			it.hold_off = hold_off && (i == 0);
			operand_queue.push_back(it);
		end
	endtask

	// random magnitude of n words with extreme words mixed in
	function automatic wide_t pick_magnitude(input int n);
		wide_t v;
		v = '0;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(9))
				0: v[i*WORD_BITS +: WORD_BITS] = '0;
				1: v[i*WORD_BITS +: WORD_BITS] = '1;
				2: v[i*WORD_BITS +: WORD_BITS] = $urandom_range(15);
				3: v[i*WORD_BITS +: WORD_BITS] = {1'b1, {(WORD_BITS-1){1'b0}}};
				default: v[i*WORD_BITS +: WORD_BITS] = $urandom();
			endcase
		end
		return v;
	endfunction

	// stimulus and end of run
	initial begin : stimulus
		wide_t a;
		wide_t b;
		wide_t m;
		op_t   code;
		logic  a_neg;
		logic  b_neg;
		int    n;
		int    nw;
		int    queued;
		int    ops;

		// directed: extremes, every operation and the corner cases
		queue_operation(OP_ADD, 0, 0, '0, '0, '0, 1, 0);
		queue_operation(OP_ADD, 0, 0, 32'hFFFF_FFFF, 32'h1, '1, 1, 0);
		// zero sum of two negatives stays negative
		queue_operation(OP_ADD, 1, 1, '0, '0, '0, 1, 0);
		// a - a is a positive zero
		queue_operation(OP_SUB, 1, 1, 32'h5, 32'h5, '0, 1, 0);
		queue_operation(OP_SUB, 0, 0, 32'h3, 32'hA, '0, 1, 0);
		queue_operation(OP_ADD, 0, 1, 32'h5, 32'hFFFF_FFFF, '0, 1, 0);
		// modular sum equal to the modulus reduces to zero
		queue_operation(OP_MADD, 0, 0, 32'h3, 32'h4, 32'h7, 1, 0);
		// first operand not below the modulus
		queue_operation(OP_MADD, 0, 0, 32'h7, 32'h1, 32'h7, 1, 0);
		queue_operation(OP_MADD, 1, 0, 32'h1, 32'h1, 32'h7, 1, 0);
		// negative modular difference gets the modulus added
		queue_operation(OP_MSUB, 0, 0, 32'h2, 32'h5, 32'h9, 1, 0);
		queue_operation(OP_MSUB, 0, 0, 32'h2, 32'h9, 32'h9, 1, 0);
		// modular sum that wraps past the word width
		queue_operation(OP_MADD, 0, 0, 32'hFFFF_FFFE, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 1, 0);
		// carry across words, sender waits for the block to drain first
		queue_operation(OP_ADD, 0, 0, 64'h0000_0000_FFFF_FFFF, 64'h1, '0, 2, 1);
		// more words than the stores hold, the extra word is dropped
		queue_operation(OP_SUB, 0, 1, '1, '1, '1, NUM_WORDS + 1, 0);

		// random operations, mostly well-formed modular operands
		queued = 0;
		ops = 0;
		while (queued < RAND_ITEMS) begin
			code = op_t'($urandom_range(3));
			case ($urandom_range(99)) inside
				[0:44]:  n = $urandom_range(2, 1);
				[45:84]: n = $urandom_range(4, 3);
				[85:94]: n = NUM_WORDS;
				default: n = $urandom_range(NUM_WORDS + 2, NUM_WORDS + 1);
			endcase
			nw = (n > NUM_WORDS) ? NUM_WORDS : n;
			a = pick_magnitude(nw);
			b = pick_magnitude(nw);
			m = pick_magnitude(nw);
			a_neg = 1'($urandom_range(1));
			b_neg = 1'($urandom_range(1));
			if ((code == OP_MADD || code == OP_MSUB) && $urandom_range(99) < 80) begin
				a_neg = 1'b0;
				b_neg = 1'b0;
				if (m == '0)
					m = 1;
				a = a % m;
				b = b % m;
				if ($urandom_range(9) == 0)
					a = m - 1;
				if ($urandom_range(9) == 0)
					b = m - 1;
			end else if ($urandom_range(99) < 15) begin
				b = a;
			end
			queue_operation(code, a_neg, b_neg, a, b, m, n, ops == 30 || ops == 70);
			queued += n;
			ops++;
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// wait for the stimulus to go in and every result to come out
		do
			@(negedge clk);
		while (operand_queue.size() != 0 || operand_valid || due_results.size() != 0);
		repeat (TAIL_WAIT) @(posedge clk);

		if (mismatches == 0 && due_results.size() == 0)
			$display("tb_multiword_signed_add_sub_mod_core OK");
		else
			$display("tb_multiword_signed_add_sub_mod_core NOT OK");
		$finish;
	end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/mwsas_pkg.sv
rtl/core/mwsas_alu.sv
rtl/core/multiword_signed_add_sub_mod_core.sv
rtl/core/mwsas_checker.sv
tb/tb_multiword_signed_add_sub_mod_core.sv
